// ===== design/lbp3_pkg.sv =====
// Shared constants and types of the 3x3 local binary pattern unit.
`default_nettype none

package lbp3_pkg;

   localparam int unsigned DATA_W            = 8;
   localparam int unsigned ROW_W             = 12;
   localparam int unsigned COL_W             = 10;
   localparam int unsigned IN_ROW_W          = 13;
   localparam int unsigned IMG_W_W           = 11;
   localparam int unsigned IMG_H_W           = 13;
   localparam int unsigned CSR_IDX_W         = 2;
   localparam int unsigned CSR_DATA_W        = 13;
   localparam int unsigned DEFAULT_MAX_WIDTH = 1024;
   localparam int unsigned MAX_HEIGHT        = 4096;
   localparam int unsigned RESET_WIDTH       = 640;
   localparam int unsigned RESET_HEIGHT      = 480;
   localparam int unsigned QUEUE_DEPTH       = 8;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   typedef struct packed {
      logic [DATA_W-1:0] pattern;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  out_col;
      logic              frame_done;
      logic              last_of_step;
   } rslt_type;

   typedef struct packed {
      logic              go;
      logic              drain;
      logic              row_ge1;
      logic              row_ge2;
      logic              col_ge1;
      logic              col_ge2;
      logic              col_last;
      logic [ROW_W-1:0]  out_row;
      logic [COL_W-1:0]  col_prev;
      logic [COL_W-1:0]  col_cur;
      logic [DATA_W-1:0] up;
      logic [DATA_W-1:0] mid;
      logic [DATA_W-1:0] pix;
   } step_type;

   typedef struct packed {
      logic     v0;
      logic     v1;
      rslt_type res0;
      rslt_type res1;
   } pair_type;

endpackage

`default_nettype wire

// ===== design/lbp3_if.sv =====
// Request, response and register write channels of the LBP unit.
`default_nettype none

interface lbp3_req_if;
   import lbp3_pkg::*;
   logic              valid;
   logic              ready;
   logic              mode;
   logic [DATA_W-1:0] pixel;
   modport source (output valid, output mode, output pixel, input ready);
   modport sink (input valid, input mode, input pixel, output ready);
endinterface

interface lbp3_rsp_if;
   import lbp3_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] pattern;
   logic [ROW_W-1:0]  out_row;
   logic [COL_W-1:0]  out_col;
   logic              frame_done;
   logic              last_of_step;
   modport source (output valid, output pattern, output out_row, output out_col,
                   output frame_done, output last_of_step, input ready);
   modport sink (input valid, input pattern, input out_row, input out_col,
                 input frame_done, input last_of_step, output ready);
endinterface

interface lbp3_csr_if;
   import lbp3_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/lbp3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lbp3_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/lbp3_window.sv =====
// 3x3 window registers and the two neighbour comparison codes of one item.
`default_nettype none

module lbp3_window (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               clear,
   input  wire lbp3_pkg::step_type step,
   output lbp3_pkg::pair_type      pair
);
   import lbp3_pkg::*;

   logic [DATA_W-1:0] win_ff [6];
   logic [DATA_W-1:0] win_in [6];
   logic [DATA_W-1:0] newcol [3];
   logic [7:0][DATA_W-1:0] nb0;
   logic [7:0][DATA_W-1:0] nb1;
   logic [7:0] en0;
   logic [7:0] en1;
   logic rok0;
   logic rok2;
   logic v0;
   logic v1;

   function automatic logic [7:0] code_of(input logic [DATA_W-1:0] ctr,
                                         input logic [7:0][DATA_W-1:0] nb,
                                         input logic [7:0] en);
      logic [7:0] code;
      for (int b = 0; b < 8; b++) begin
         code[b] = en[b] && (ctr < nb[b]);
      end
      return code;
   endfunction

   always_comb begin
      newcol[0] = step.up;
      newcol[1] = step.mid;
      newcol[2] = step.drain ? '0 : step.pix;
      rok0 = step.row_ge2;
      rok2 = !step.drain;

      nb0[0] = win_ff[0];
      nb0[1] = win_ff[1];
      nb0[2] = newcol[0];
      nb0[3] = win_ff[2];
      nb0[4] = newcol[1];
      nb0[5] = win_ff[4];
      nb0[6] = win_ff[5];
      nb0[7] = newcol[2];
      en0[0] = rok0 && step.col_ge2;
      en0[1] = rok0;
      en0[2] = rok0;
      en0[3] = step.col_ge2;
      en0[4] = 1'b1;
      en0[5] = rok2 && step.col_ge2;
      en0[6] = rok2;
      en0[7] = rok2;

      nb1[0] = win_ff[1];
      nb1[1] = newcol[0];
      nb1[2] = '0;
      nb1[3] = win_ff[3];
      nb1[4] = '0;
      nb1[5] = win_ff[5];
      nb1[6] = newcol[2];
      nb1[7] = '0;
      en1[0] = rok0 && step.col_ge1;
      en1[1] = rok0;
      en1[2] = 1'b0;
      en1[3] = step.col_ge1;
      en1[4] = 1'b0;
      en1[5] = rok2 && step.col_ge1;
      en1[6] = rok2;
      en1[7] = 1'b0;

      v0 = step.go && step.row_ge1 && step.col_ge1;
      v1 = step.go && step.row_ge1 && step.col_last;

      pair.v0                = v0;
      pair.v1                = v1;
      pair.res0.pattern      = code_of(win_ff[3], nb0, en0);
      pair.res0.out_row      = step.out_row;
      pair.res0.out_col      = step.col_prev;
      pair.res0.frame_done   = 1'b0;
      pair.res0.last_of_step = !v1;
      pair.res1.pattern      = code_of(newcol[1], nb1, en1);
      pair.res1.out_row      = step.out_row;
      pair.res1.out_col      = step.col_cur;
      pair.res1.frame_done   = step.drain;
      pair.res1.last_of_step = 1'b1;

      for (int y = 0; y < 3; y++) begin
         win_in[2*y]   = win_ff[2*y+1];
         win_in[2*y+1] = newcol[y];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (step.go) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/lbp3_rsp_queue.sv =====
// Result queue taking up to two results per cycle and giving one while out_ready is high.
`default_nettype none

module lbp3_rsp_queue #(
   parameter int unsigned DEPTH = lbp3_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lbp3_pkg::pair_type pair,
   output logic                    room,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output lbp3_pkg::rslt_type      out_item
);
   import lbp3_pkg::*;

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rslt_type       q_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff;
   logic [PW-1:0]  rd_ptr_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [PW-1:0]  wr_next;
   logic [1:0]     n_push;
   logic [CW:0]    fill;
   logic           pop;
   rslt_type       first;

   always_comb begin
      n_push    = {1'b0, pair.v0} + {1'b0, pair.v1};
      fill      = {1'b0, count_ff} + (CW+1)'(n_push);
      room      = fill <= (CW+1)'(DEPTH - 2);
      out_valid = count_ff != '0;
      out_item  = q_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      first     = pair.v0 ? pair.res0 : pair.res1;
      wr_next   = wr_ptr_ff + PW'(1);
      wr_ptr_in = wr_ptr_ff + PW'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(n_push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pair.v0 || pair.v1) begin
         q_ff[wr_ptr_ff] <= first;
      end
      if (pair.v0 && pair.v1) begin
         q_ff[wr_next] <= pair.res1;
      end
   end

endmodule

`default_nettype wire

// ===== design/local_binary_pattern_3x3_unit.sv =====
// Top level of the streaming 3x3 local binary pattern unit.
//
// req carries grey pixels in raster order (mode 0) and, after a frame's last
// pixel, image_width drain items (mode 1) that flush the final row. rsp gives
// one LBP code per pixel with its row, column, frame_done on the frame's last
// code and last_of_step on the final result of each request item.
// The item at (r, c) releases the code of (r-1, c-1), and at the row's end
// also the code of (r-1, width-1); row 0 releases nothing.
// Throughput: one item per cycle, set by one read and one write of the packed
// line store per cycle; results drain through an eight-entry queue at one per
// cycle unless rsp stalls, and req.ready drops while that queue could not take
// two more. csr writes image_width (index 0) or image_height (index 1); the
// user must write them only while idle, which the block does not enforce. A
// write to either restarts the frame. Reset clears position, window and queue
// and sets 640 x 480; line store is not cleared. A stalled rsp holds its item.
`default_nettype none

module local_binary_pattern_3x3_unit #(
   parameter int unsigned MAX_WIDTH = lbp3_pkg::DEFAULT_MAX_WIDTH
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lbp3_req_if.sink   req,
   lbp3_rsp_if.source rsp,
   lbp3_csr_if.sink   csr
);
   import lbp3_pkg::*;

   localparam int unsigned AW    = $clog2(MAX_WIDTH);
   localparam int unsigned WIDW  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned CMPW  = ((WIDW > IMG_W_W) ? WIDW : IMG_W_W) + 1;
   localparam int unsigned LINEW = 2 * DATA_W;

   function automatic logic [AW-1:0] width_last(input logic [IMG_W_W-1:0] iw);
      logic [CMPW-1:0] ext;
      ext = CMPW'(iw);
      if (iw == '0) begin
         return '0;
      end else if (ext >= CMPW'(MAX_WIDTH)) begin
         return AW'(MAX_WIDTH - 1);
      end else begin
         ext = ext - CMPW'(1);
         return ext[AW-1:0];
      end
   endfunction

   function automatic logic [IN_ROW_W-1:0] height_eff(input logic [IMG_H_W-1:0] ih);
      if (ih == '0) begin
         return IN_ROW_W'(1);
      end else if (ih > IMG_H_W'(MAX_HEIGHT)) begin
         return IN_ROW_W'(MAX_HEIGHT);
      end else begin
         return IN_ROW_W'(ih);
      end
   endfunction

   logic [AW-1:0]       wlast_ff;
   logic [AW-1:0]       wlast_in;
   logic [IN_ROW_W-1:0] height_ff;
   logic [IN_ROW_W-1:0] height_in;
   logic [IN_ROW_W-1:0] row_ff;
   logic [IN_ROW_W-1:0] row_in;
   logic [AW-1:0]       col_ff;
   logic [AW-1:0]       col_in;

   logic                s1_valid_ff;
   logic                s1_drain_ff;
   logic [DATA_W-1:0]   s1_pix_ff;
   logic [IN_ROW_W-1:0] s1_row_ff;
   logic [AW-1:0]       s1_col_ff;
   logic                s1_last_ff;
   logic                fwd_ff;
   logic                fwd_in;
   logic [LINEW-1:0]    fwd_data_ff;

   logic                restart;
   logic                req_acc;
   logic                ignore;
   logic                take;
   logic                col_last_now;
   logic                wr_en;
   logic [LINEW-1:0]    wr_data;
   logic [LINEW-1:0]    ram_q;
   logic [LINEW-1:0]    line;
   logic [IN_ROW_W-1:0] row_prev;
   logic [AW-1:0]       col_prev;
   logic                room;
   logic                q_valid;
   step_type            step;
   pair_type            pair;
   rslt_type            q_item;

   assign csr.ready = 1'b1;

   always_comb begin
      restart   = 1'b0;
      wlast_in  = wlast_ff;
      height_in = height_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_IMAGE_WIDTH: begin
               wlast_in = width_last(csr.data[IMG_W_W-1:0]);
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = height_eff(csr.data[IMG_H_W-1:0]);
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      req.ready    = room;
      req_acc      = req.valid && req.ready;
      ignore       = req.mode ? (row_ff != height_ff) : (row_ff >= height_ff);
      take         = req_acc && !ignore;
      col_last_now = col_ff == wlast_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (take) begin
         if (col_last_now) begin
            col_in = '0;
            row_in = req.mode ? '0 : row_ff + IN_ROW_W'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= width_last(IMG_W_W'(RESET_WIDTH));
         height_ff   <= height_eff(IMG_H_W'(RESET_HEIGHT));
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         wlast_ff    <= wlast_in;
         height_ff   <= height_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= take;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_drain_ff <= req.mode;
         s1_pix_ff   <= req.pixel;
         s1_row_ff   <= row_ff;
         s1_col_ff   <= col_ff;
         s1_last_ff  <= col_last_now;
      end
      fwd_data_ff <= wr_data;
   end

   always_comb begin
      line     = fwd_ff ? fwd_data_ff : ram_q;
      wr_en    = s1_valid_ff && !s1_drain_ff;
      wr_data  = {line[DATA_W-1:0], s1_pix_ff};
      fwd_in   = wr_en && (s1_col_ff == col_ff);
      row_prev = s1_row_ff - IN_ROW_W'(1);
      col_prev = s1_col_ff - AW'(1);

      step.go       = s1_valid_ff;
      step.drain    = s1_drain_ff;
      step.row_ge1  = s1_row_ff >= IN_ROW_W'(1);
      step.row_ge2  = s1_row_ff >= IN_ROW_W'(2);
      step.col_ge1  = s1_col_ff >= AW'(1);
      step.col_ge2  = s1_col_ff >= AW'(2);
      step.col_last = s1_last_ff;
      step.out_row  = row_prev[ROW_W-1:0];
      step.col_prev = COL_W'(col_prev);
      step.col_cur  = COL_W'(s1_col_ff);
      step.up       = line[LINEW-1:DATA_W];
      step.mid      = line[DATA_W-1:0];
      step.pix      = s1_pix_ff;
   end

   lbp3_ram #(
      .WIDTH (LINEW),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_addr (col_ff),
      .rd_data (ram_q)
   );

   lbp3_window u_window (
      .clock (clock),
      .reset (reset),
      .clear (restart),
      .step  (step),
      .pair  (pair)
   );

   lbp3_rsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .pair      (pair),
      .room      (room),
      .out_valid (q_valid),
      .out_ready (rsp.ready),
      .out_item  (q_item)
   );

   assign rsp.valid        = q_valid;
   assign rsp.pattern      = q_item.pattern;
   assign rsp.out_row      = q_item.out_row;
   assign rsp.out_col      = q_item.out_col;
   assign rsp.frame_done   = q_item.frame_done;
   assign rsp.last_of_step = q_item.last_of_step;

endmodule

`default_nettype wire

// ===== design/lbp3_chk.sv =====
// Port-level checks of the LBP unit and their binding to the top level.
`default_nettype none

module lbp3_chk (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic [lbp3_pkg::DATA_W-1:0] rsp_pattern,
   input wire logic [lbp3_pkg::ROW_W-1:0]  rsp_out_row,
   input wire logic [lbp3_pkg::COL_W-1:0]  rsp_out_col,
   input wire logic                        rsp_frame_done,
   input wire logic                        rsp_last_of_step
);
   import lbp3_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pattern) &&
      $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_frame_done) &&
      $stable(rsp_last_of_step))
      else $error("rsp item changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_step)
      else $error("frame_done on an item that is not last of its step");

   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_step |=> rsp_valid)
      else $error("second result of a step missing");

endmodule

bind local_binary_pattern_3x3_unit lbp3_chk u_lbp3_chk (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_pattern      (rsp.pattern),
   .rsp_out_row      (rsp.out_row),
   .rsp_out_col      (rsp.out_col),
   .rsp_frame_done   (rsp.frame_done),
   .rsp_last_of_step (rsp.last_of_step)
);

`default_nettype wire

// ===== tb/tb_local_binary_pattern_3x3_unit.sv =====
// Self-checking testbench of the 3x3 local binary pattern unit: predicts every code and compares.
module tb_local_binary_pattern_3x3_unit;
   import lbp3_pkg::*;

   localparam int unsigned MAX_COLS       = DEFAULT_MAX_WIDTH;
   localparam int unsigned RANDOM_ITEMS   = 400;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   localparam int unsigned MAX_SHOWN      = 10;

   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_B = 2'd3;

   typedef enum int {PIX_FULL, PIX_NEAR, PIX_EXTREME} pixel_style_type;

   logic clock = 1'b0;
   logic reset;

   lbp3_req_if req_ch ();
   lbp3_rsp_if rsp_ch ();
   lbp3_csr_if csr_ch ();

   local_binary_pattern_3x3_unit uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bit [DATA_W-1:0]  row2_px [MAX_COLS];
   bit [DATA_W-1:0]  row1_px [MAX_COLS];
   bit [DATA_W-1:0]  win_px [6];
   int unsigned      pos_row = 0;
   int unsigned      pos_col = 0;
   bit [IMG_W_W-1:0] width_reg = IMG_W_W'(RESET_WIDTH);
   bit [IMG_H_W-1:0] height_reg = IMG_H_W'(RESET_HEIGHT);

   rslt_type    expected_codes [$];
   int unsigned fail_count = 0;
   int unsigned burst_left = 0;
   bit          steady_feed = 1'b0;
   bit          rsp_hold_request = 1'b0;

   function automatic logic [7:0] lbp_of(input logic [2:0][2:0][7:0] v,
                                         input logic [2:0] row_ok, input logic [2:0] col_ok);
      logic [7:0] code;
      int b, y, x;
      code = '0;
      b = 0;
      for (y = 0; y < 3; y++)
         for (x = 0; x < 3; x++)
            if (y != 1 || x != 1) begin
               code[b] = row_ok[y] && col_ok[x] && (v[y][x] > v[1][1]);
               b++;
            end
      return code;
   endfunction

   task automatic predict_lbp_codes(input logic is_drain, input logic [DATA_W-1:0] px);
      int unsigned w, h, r, c, y;
      logic [2:0][7:0] fresh;
      logic [2:0][2:0][7:0] v;
      logic [2:0] row_ok, col_ok;
      rslt_type code_a, code_b;
      bit have_a, have_b;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_COLS) ? MAX_COLS : width_reg);
      h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
      r = pos_row;
      c = pos_col;
      if (is_drain ? (r != h) : (r >= h)) return;
      if (c >= w) c = 0;
      fresh[0] = row2_px[c];
      fresh[1] = row1_px[c];
      fresh[2] = is_drain ? 8'h00 : px;
      row_ok = {!is_drain, 1'b1, r >= 2};
      have_a = 1'b0;
      have_b = 1'b0;
      code_a = '0;
      code_b = '0;
      if (r >= 1 && c >= 1) begin
         for (y = 0; y < 3; y++) begin
            v[y][0] = win_px[2*y];
            v[y][1] = win_px[2*y+1];
            v[y][2] = fresh[y];
         end
         col_ok = {1'b1, 1'b1, c >= 2};
         code_a.pattern = lbp_of(v, row_ok, col_ok);
         code_a.out_row = 12'(r - 1);
         code_a.out_col = 10'(c - 1);
         have_a = 1'b1;
      end
      if (r >= 1 && c == w - 1) begin
         for (y = 0; y < 3; y++) begin
            v[y][0] = win_px[2*y+1];
            v[y][1] = fresh[y];
            v[y][2] = 8'h00;
         end
         col_ok = {1'b0, 1'b1, c >= 1};
         code_b.pattern = lbp_of(v, row_ok, col_ok);
         code_b.out_row = 12'(r - 1);
         code_b.out_col = 10'(c);
         code_b.frame_done = is_drain;
         code_b.last_of_step = 1'b1;
         have_b = 1'b1;
      end
      if (have_a) begin
         code_a.last_of_step = !have_b;
         expected_codes.push_back(code_a);
      end
      if (have_b) expected_codes.push_back(code_b);
      for (y = 0; y < 3; y++) begin
         win_px[2*y] = win_px[2*y+1];
         win_px[2*y+1] = fresh[y];
      end
      if (!is_drain) begin
         row2_px[c] = row1_px[c];
         row1_px[c] = px;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r = is_drain ? 0 : r + 1;
      end
      pos_col = c;
      pos_row = r;
   endtask

   always @(posedge clock) begin
      rslt_type want;
      int k;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_codes.size() == 0) begin
               if (fail_count < MAX_SHOWN)
                  $display("unexpected code %h at row %0d col %0d done %b last %b",
                           rsp_ch.pattern, rsp_ch.out_row, rsp_ch.out_col,
                           rsp_ch.frame_done, rsp_ch.last_of_step);
               fail_count++;
            end else begin
               want = expected_codes.pop_front();
               if (rsp_ch.pattern !== want.pattern || rsp_ch.out_row !== want.out_row ||
                   rsp_ch.out_col !== want.out_col || rsp_ch.frame_done !== want.frame_done ||
                   rsp_ch.last_of_step !== want.last_of_step) begin
                  if (fail_count < MAX_SHOWN)
                     $display({"code mismatch: expected pattern %h row %0d col %0d done %b",
                               " last %b, got pattern %h row %0d col %0d done %b last %b"},
                              want.pattern, want.out_row, want.out_col, want.frame_done,
                              want.last_of_step, rsp_ch.pattern, rsp_ch.out_row,
                              rsp_ch.out_col, rsp_ch.frame_done, rsp_ch.last_of_step);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            predict_lbp_codes(req_ch.mode, req_ch.pixel);
         if (csr_ch.valid && csr_ch.ready &&
             (csr_ch.index == REG_IMAGE_WIDTH || csr_ch.index == REG_IMAGE_HEIGHT)) begin
            if (csr_ch.index == REG_IMAGE_WIDTH)
               width_reg = csr_ch.data[IMG_W_W-1:0];
            else
               height_reg = csr_ch.data[IMG_H_W-1:0];
            pos_row = 0;
            pos_col = 0;
            for (k = 0; k < 6; k++) win_px[k] = '0;
         end
      end
   end

   initial begin : rsp_ready_pattern
      int unsigned span, duty, k;
      rsp_ch.ready = 1'b0;
      forever begin
         if (rsp_hold_request) begin
            rsp_ch.ready <= 1'b0;
            for (k = 0; k < HOLD_CYCLES; k++) @(posedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            span = $urandom_range(4, 80);
            case ($urandom_range(0, 4))
               0, 1: duty = 100;
               2: duty = 70;
               3: duty = 40;
               default: duty = 15;
            endcase
            k = 0;
            while (k < span && !rsp_hold_request) begin
               rsp_ch.ready <= ($urandom_range(1, 100) <= duty);
               @(posedge clock);
               k++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int unsigned idle_cycles;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL local_binary_pattern_3x3_unit");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pick_pixel(input pixel_style_type style,
                                                     input logic [DATA_W-1:0] base);
      case (style)
         PIX_FULL: return 8'($urandom);
         PIX_NEAR: return base + 8'($urandom_range(0, 3));
         default:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   task automatic send_item(input logic item_mode, input logic [DATA_W-1:0] item_pixel);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!steady_feed && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
      end
      burst_left--;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode  <= item_mode;
      req_ch.pixel <= item_pixel;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic set_frame(input logic [CSR_DATA_W-1:0] wdata, input logic [CSR_DATA_W-1:0] hdata);
      wait_idle();
      csr_write(REG_IMAGE_WIDTH, wdata);
      csr_write(REG_IMAGE_HEIGHT, hdata);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_frame(input int unsigned w, input int unsigned h,
                             input pixel_style_type style);
      logic [DATA_W-1:0] base;
      int unsigned k;
      base = 8'($urandom_range(0, 252));
      for (k = 0; k < w * h; k++) send_item(MODE_PIXEL, pick_pixel(style, base));
      repeat (w) send_item(MODE_DRAIN, 8'($urandom));
   endtask

   task automatic test_pattern_extremes();
      int unsigned k;
      set_frame(13'd3, 13'd3);
      for (k = 0; k < 9; k++) send_item(MODE_PIXEL, (k % 2) ? 8'hFF : 8'h00);
      repeat (3) send_item(MODE_DRAIN, 8'($urandom));
      for (k = 0; k < 9; k++) send_item(MODE_PIXEL, 8'h80);
      repeat (3) send_item(MODE_DRAIN, 8'($urandom));
   endtask

   task automatic test_tiny_frames();
      set_frame(13'd0, 13'd0);
      send_frame(1, 1, PIX_FULL);
      set_frame(13'd1, 13'd1);
      send_frame(1, 1, PIX_FULL);
      set_frame(13'd2, 13'd2);
      send_frame(2, 2, PIX_EXTREME);
      set_frame(13'd1, 13'd3);
      send_frame(1, 3, PIX_NEAR);
   endtask

   task automatic test_ignored_items();
      int unsigned k;
      set_frame(13'd2, 13'd2);
      send_item(MODE_DRAIN, 8'($urandom));
      for (k = 0; k < 4; k++) send_item(MODE_PIXEL, 8'($urandom));
      send_item(MODE_PIXEL, 8'hAA);
      send_item(MODE_PIXEL, 8'h55);
      repeat (2) send_item(MODE_DRAIN, 8'($urandom));
      send_item(MODE_DRAIN, 8'($urandom));
   endtask

   task automatic test_register_restart();
      int unsigned k;
      set_frame(13'd4, 13'd3);
      for (k = 0; k < 6; k++) send_item(MODE_PIXEL, 8'($urandom));
      wait_idle();
      csr_write(REG_UNUSED_A, 13'($urandom));
      csr_write(REG_UNUSED_B, 13'($urandom));
      csr_ch.valid <= 1'b0;
      for (k = 0; k < 6; k++) send_item(MODE_PIXEL, 8'($urandom));
      wait_idle();
      csr_write(REG_IMAGE_HEIGHT, 13'd2);
      csr_ch.valid <= 1'b0;
      send_frame(4, 2, PIX_NEAR);
   endtask

   task automatic test_largest_frames();
      int unsigned k;
      set_frame(13'h1FFF, 13'h1FFF);
      for (k = 0; k < MAX_COLS + 16; k++) send_item(MODE_PIXEL, 8'($urandom));
   endtask

   task automatic test_output_backpressure();
      set_frame(13'd16, 13'd4);
      steady_feed = 1'b1;
      rsp_hold_request = 1'b1;
      send_frame(16, 4, PIX_FULL);
      steady_feed = 1'b0;
   endtask

   task automatic test_random_frames();
      int unsigned counted, w, h, npix, ndrain, k, fate;
      logic [CSR_DATA_W-1:0] wdata, hdata;
      pixel_style_type style;
      logic [DATA_W-1:0] base;
      bit clean;
      counted = 0;
      clean = 1'b0;
      w = 1;
      h = 1;
      while (counted < RANDOM_ITEMS) begin
         if (!clean || $urandom_range(0, 3) != 0) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
            h = $urandom_range(1, 6);
            wdata = {2'($urandom), 11'(w)};
            hdata = 13'(h);
            if ($urandom_range(0, 15) == 0) begin
               w = 1;
               wdata[IMG_W_W-1:0] = '0;
            end
            if ($urandom_range(0, 15) == 0) begin
               h = 1;
               hdata = '0;
            end
            set_frame(wdata, hdata);
         end
         style = pixel_style_type'($urandom_range(0, 2));
         base = 8'($urandom_range(0, 252));
         fate = $urandom_range(0, 9);
         npix = (fate == 0) ? $urandom_range(0, w * h - 1) : w * h;
         for (k = 0; k < npix; k++) begin
            if ($urandom_range(0, 24) == 0) send_item(MODE_DRAIN, 8'($urandom));
            send_item(MODE_PIXEL, pick_pixel(style, base));
            counted++;
         end
         if (fate != 0) begin
            if (fate == 1)
               repeat ($urandom_range(1, 3)) send_item(MODE_PIXEL, 8'($urandom));
            ndrain = (fate == 2) ? $urandom_range(0, w - 1) : w;
            repeat (ndrain) send_item(MODE_DRAIN, 8'($urandom));
            counted += ndrain;
         end
         clean = (fate > 2);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode  = MODE_PIXEL;
      req_ch.pixel = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = REG_IMAGE_WIDTH;
      csr_ch.data  = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_pattern_extremes();
      test_tiny_frames();
      test_ignored_items();
      test_register_restart();
      test_largest_frames();
      test_output_backpressure();
      test_random_frames();
      wait_idle();
      if (fail_count == 0 && expected_codes.size() == 0)
         $display("PASS local_binary_pattern_3x3_unit");
      else
         $display("FAIL local_binary_pattern_3x3_unit");
      $finish;
   end

endmodule

// ===== files.f =====
design/lbp3_pkg.sv
design/lbp3_if.sv
design/lbp3_ram.sv
design/lbp3_window.sv
design/lbp3_rsp_queue.sv
design/local_binary_pattern_3x3_unit.sv
design/lbp3_chk.sv
tb/tb_local_binary_pattern_3x3_unit.sv
